### rtl/core/rcm_pkg.sv
// Package with the shared constants, types and register indexes of the RMS current meter.
package rcm_pkg;

    localparam int ADC_BITS    = 12;
    localparam int WINDOW_BITS = 16;

    localparam int SQ_W     = 2 * ADC_BITS;
    localparam int SUM_W    = 40;
    localparam int SCALED_W = SUM_W + 8;
    localparam int ROOT_W   = SCALED_W + 1;

    localparam int GAIN_W  = 24;
    localparam int GATE_W  = 16;
    localparam int VOLT_W  = 9;
    localparam int RMS_W   = 16;
    localparam int CUR_W   = 16;
    localparam int PWR_W   = 25;
    localparam int PROD_W  = RMS_W + GAIN_W;
    localparam int SHIFT_Q = 20;

    localparam int DIV_STEPS  = SCALED_W;
    localparam int SQRT_STEPS = SCALED_W / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int IN_TDATA_W  = ((ADC_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS  = RMS_W + CUR_W + PWR_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS + 7) / 8) * 8;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W0    = (ADC_BITS > WINDOW_BITS) ? ADC_BITS : WINDOW_BITS;
    localparam int CFG_W     = (CFG_W0 > GAIN_W) ? CFG_W0 : GAIN_W;

    localparam logic [CFG_IDX_W-1:0] REG_ADC_MIDPOINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GATE         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE      = 3'd4;

    typedef struct packed {
        logic [ADC_BITS-1:0]    adc_midpoint;
        logic [WINDOW_BITS-1:0] window_length;
        logic [GAIN_W-1:0]      current_gain_q16;
        logic [GATE_W-1:0]      gate_threshold_ma;
        logic [VOLT_W-1:0]      line_voltage_v;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_MUL,
        ST_GATE,
        ST_PWR
    } back_state_t;

    typedef struct packed {
        logic pop;
        logic load_div;
        logic div_step;
        logic load_sqrt;
        logic sqrt_step;
        logic do_mul;
        logic do_gate;
        logic load_out;
    } back_ctl_t;

endpackage

### rtl/core/rcm_front.sv
// Front part: centers and squares each sample and accumulates the window sum.
module rcm_front
    import rcm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [ADC_BITS-1:0]    sample,
    input  logic                   q_full,
    output logic                   q_push,
    output logic [SUM_W-1:0]       q_data
);

    logic                   s1_valid_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [WINDOW_BITS-1:0] cnt_reg;

    logic [ADC_BITS-1:0]    diff;
    logic [SUM_W:0]         sum_add;
    logic [SUM_W-1:0]       sum_sat;
    logic [WINDOW_BITS-1:0] cnt_inc;
    logic [WINDOW_BITS-1:0] win;
    logic                   done;
    logic                   s2_fire;

    assign diff = (sample >= cfg.adc_midpoint) ? (sample - cfg.adc_midpoint)
                                               : (cfg.adc_midpoint - sample);

    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);
    assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign cnt_inc = cnt_reg + WINDOW_BITS'(1);
    assign win     = (cfg.window_length == '0) ? WINDOW_BITS'(1) : cfg.window_length;
    assign done    = (cnt_inc == '0) || (cnt_inc >= win);

    assign s2_fire  = s1_valid_reg && !(done && q_full);
    assign s_tready = !s1_valid_reg || s2_fire;
    assign q_push   = s2_fire && done;
    assign q_data   = sum_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_fire)
            begin
                sum_reg <= done ? '0 : sum_sat;
                cnt_reg <= done ? '0 : cnt_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sq_reg <= SQ_W'(diff) * SQ_W'(diff);
        end
    end

endmodule

### rtl/core/rcm_queue.sv
// Short queue of finished window sums between the front and back parts.
module rcm_queue
    import rcm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [SUM_W-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [SUM_W-1:0] pop_data
);

    logic [SUM_W-1:0]   mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign valid    = (cnt_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + Q_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/rcm_back.sv
// Back part: divides by the window, takes the square root and scales to current and power.
module rcm_back
    import rcm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             q_valid,
    input  logic [SUM_W-1:0] q_data,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [RMS_W-1:0] rms_q4,
    output logic [CUR_W-1:0] current_ma,
    output logic [PWR_W-1:0] power_mw
);

    back_state_t state_reg;
    back_state_t state_next;
    back_ctl_t   ctl;

    logic [STEP_W-1:0]      step_reg;
    logic [SCALED_W-1:0]    qd_reg;
    logic [WINDOW_BITS-1:0] rem_reg;
    logic [SCALED_W-1:0]    v_reg;
    logic [ROOT_W-1:0]      root_reg;
    logic [SCALED_W-1:0]    bit_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [CUR_W-1:0]       cur_reg;
    logic                   out_valid_reg;
    logic [RMS_W-1:0]       rms_reg;
    logic [RMS_W-1:0]       rms_out_reg;
    logic [CUR_W-1:0]       cur_out_reg;
    logic [PWR_W-1:0]       pwr_out_reg;

    logic [WINDOW_BITS-1:0] win;
    logic [WINDOW_BITS:0]   rem_sh;
    logic                   ge;
    logic [WINDOW_BITS:0]   rem_sub;
    logic [ROOT_W-1:0]      trial;
    logic                   take;
    logic [RMS_W-1:0]       rms_sat;
    logic [SHIFT_Q-1:0]     cur_full;
    logic [CUR_W-1:0]       cur_sat;
    logic                   out_free;

    assign win     = (cfg.window_length == '0) ? WINDOW_BITS'(1) : cfg.window_length;
    assign rem_sh  = {rem_reg, qd_reg[SCALED_W-1]};
    assign ge      = rem_sh >= {1'b0, win};
    assign rem_sub = rem_sh - {1'b0, win};

    assign trial   = root_reg + ROOT_W'(bit_reg);
    assign take    = ROOT_W'(v_reg) >= trial;

    assign rms_sat  = (root_reg[ROOT_W-1:RMS_W] != '0) ? {RMS_W{1'b1}}
                                                       : root_reg[RMS_W-1:0];
    assign cur_full = prod_reg[PROD_W-1:SHIFT_Q];
    assign cur_sat  = (cur_full[SHIFT_Q-1:CUR_W] != '0) ? {CUR_W{1'b1}}
                                                        : cur_full[CUR_W-1:0];
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_SQRT_INIT;
                end
            end
            ST_SQRT_INIT:
            begin
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_GATE;
            end
            ST_GATE:
            begin
                state_next = ST_PWR;
            end
            ST_PWR:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.pop      = q_valid;
                ctl.load_div = q_valid;
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
            end
            ST_SQRT_INIT:
            begin
                ctl.load_sqrt = 1'b1;
            end
            ST_SQRT:
            begin
                ctl.sqrt_step = 1'b1;
            end
            ST_MUL:
            begin
                ctl.do_mul = 1'b1;
            end
            ST_GATE:
            begin
                ctl.do_gate = 1'b1;
            end
            ST_PWR:
            begin
                ctl.load_out = out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    assign q_pop = ctl.pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.load_div)
            begin
                step_reg <= STEP_W'(DIV_STEPS - 1);
            end
            else if (ctl.load_sqrt)
            begin
                step_reg <= STEP_W'(SQRT_STEPS - 1);
            end
            else if (ctl.div_step || ctl.sqrt_step)
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_div)
        begin
            qd_reg  <= {q_data, 8'b0};
            rem_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            qd_reg  <= {qd_reg[SCALED_W-2:0], ge};
            rem_reg <= ge ? rem_sub[WINDOW_BITS-1:0] : rem_sh[WINDOW_BITS-1:0];
        end
        if (ctl.load_sqrt)
        begin
            v_reg    <= qd_reg;
            root_reg <= '0;
            bit_reg  <= SCALED_W'(1) << (SCALED_W - 2);
        end
        else if (ctl.sqrt_step)
        begin
            if (take)
            begin
                v_reg    <= v_reg - trial[SCALED_W-1:0];
                root_reg <= (root_reg >> 1) + ROOT_W'(bit_reg);
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (ctl.do_mul)
        begin
            rms_reg  <= rms_sat;
            prod_reg <= PROD_W'(rms_sat) * PROD_W'(cfg.current_gain_q16);
        end
        if (ctl.do_gate)
        begin
            cur_reg <= (cur_sat < cfg.gate_threshold_ma) ? '0 : cur_sat;
        end
        if (ctl.load_out)
        begin
            rms_out_reg <= rms_reg;
            cur_out_reg <= cur_reg;
            pwr_out_reg <= PWR_W'(cur_reg) * PWR_W'(cfg.line_voltage_v);
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign rms_q4     = rms_out_reg;
    assign current_ma = cur_out_reg;
    assign power_mw   = pwr_out_reg;

endmodule

### rtl/core/rms_current_meter_top.sv
// Top level of the RMS current meter: configuration registers and the front, queue and back parts.
//
// The slave stream takes one raw ADC sample per word in s_tdata and the block accepts a word
// in every cycle while s_tready is high. Each sample is centered on adc_midpoint, squared and
// added to a saturating 40-bit sum. When window_length samples have been taken (a zero length
// counts as one), the sum goes into a two-entry queue and the window restarts.
// The back part takes one sum at a time: after the pop it runs a restoring divider, a root
// setup step, a bit-pair square root and the scaling states ST_MUL, ST_GATE and ST_PWR.
// m_tvalid comes from the output register that ST_PWR loads. Sample throughput is one word
// per cycle while the back part finishes each window before the queue fills; with short
// windows the back part limits it.
// The result sits in an output register until m_tready takes it. While it waits the back part
// works on the next window up to ST_PWR, and when the queue is full the word that would close
// a window waits in the square register with s_tready low, so nothing is lost.
// Configuration writes land on the rising edge at which cfg_we is high.
// Reset clears the sum, the sample count, the queue and the output valid, and loads the
// default configuration.
module rms_current_meter_top
    import rcm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // rms_q4, current_ma, power_mw
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    cfg_t cfg_reg;

    logic             q_full;
    logic             q_push;
    logic [SUM_W-1:0] q_push_data;
    logic             q_pop;
    logic             q_valid;
    logic [SUM_W-1:0] q_pop_data;
    logic [RMS_W-1:0] rms_q4;
    logic [CUR_W-1:0] current_ma;
    logic [PWR_W-1:0] power_mw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adc_midpoint      <= ADC_BITS'(1951);
            cfg_reg.window_length     <= WINDOW_BITS'(2000);
            cfg_reg.current_gain_q16  <= GAIN_W'(320080);
            cfg_reg.gate_threshold_ma <= GATE_W'(80);
            cfg_reg.line_voltage_v    <= VOLT_W'(127);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ADC_MIDPOINT: cfg_reg.adc_midpoint      <= cfg_data[ADC_BITS-1:0];
                REG_WINDOW_LEN:   cfg_reg.window_length     <= cfg_data[WINDOW_BITS-1:0];
                REG_GAIN:         cfg_reg.current_gain_q16  <= cfg_data[GAIN_W-1:0];
                REG_GATE:         cfg_reg.gate_threshold_ma <= cfg_data[GATE_W-1:0];
                REG_VOLTAGE:      cfg_reg.line_voltage_v    <= cfg_data[VOLT_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    rcm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sample   (s_tdata[ADC_BITS-1:0]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    rcm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_pop_data)
    );

    rcm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_data     (q_pop_data),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .rms_q4     (rms_q4),
        .current_ma (current_ma),
        .power_mw   (power_mw)
    );

    assign m_tdata = OUT_TDATA_W'({power_mw, current_ma, rms_q4});

endmodule

### test/tb_rms_current_meter_top.sv
// Self-checking testbench for the RMS current meter top level.
module tb_rms_current_meter_top;
    import rcm_pkg::*;

    localparam int BACK_LATENCY = 100;

    typedef struct {
        logic [RMS_W-1:0] rms;
        logic [CUR_W-1:0] cur;
        logic [PWR_W-1:0] pwr;
    } reading_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    logic [ADC_BITS-1:0]    mdl_mid;
    logic [WINDOW_BITS-1:0] mdl_window;
    logic [GAIN_W-1:0]      mdl_gain;
    logic [GATE_W-1:0]      mdl_gate;
    logic [VOLT_W-1:0]      mdl_volt;
    logic [SUM_W-1:0]       mdl_sum;
    logic [WINDOW_BITS-1:0] mdl_count;

    reading_t pending_readings[$];

    bit steady = 1'b0;
    int hold_left = 0;
    int mismatches = 0;
    int readings_checked = 0;
    int readings_expected = 0;
    int samples_sent = 0;
    int reg_writes = 0;

    rms_current_meter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #24_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 24; i >= 0; i--)
        begin
            trial = root | (32'd1 << i);
            if (64'(trial) * 64'(trial) <= v)
                root = trial;
        end
        return root;
    endfunction

    task automatic model_reset();
        mdl_mid    = 12'd1951;
        mdl_window = 16'd2000;
        mdl_gain   = 24'd320080;
        mdl_gate   = 16'd80;
        mdl_volt   = 9'd127;
        mdl_sum    = '0;
        mdl_count  = '0;
    endtask

    // Accumulates one accepted sample and queues the reading when its window closes.
    task automatic account_sample(input logic [ADC_BITS-1:0] s);
        logic [ADC_BITS-1:0]    diff;
        logic [SQ_W-1:0]        sq;
        logic [SUM_W:0]         wide_sum;
        logic [WINDOW_BITS-1:0] win;
        logic [63:0]            scaled;
        logic [31:0]            root;
        logic [PROD_W-1:0]      prod;
        logic [CUR_W-1:0]       cur;
        reading_t               r;
        diff = (s >= mdl_mid) ? s - mdl_mid : mdl_mid - s;
        sq = SQ_W'(diff) * SQ_W'(diff);
        wide_sum = {1'b0, mdl_sum} + (SUM_W + 1)'(sq);
        mdl_sum = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
        mdl_count = mdl_count + 1'b1;
        win = (mdl_window == '0) ? WINDOW_BITS'(1) : mdl_window;
        if (mdl_count != '0 && mdl_count < win)
            return;
        scaled = (64'(mdl_sum) << 8) / 64'(win);
        root = floor_sqrt(scaled);
        r.rms = (root > 32'hFFFF) ? '1 : root[RMS_W-1:0];
        prod = PROD_W'(r.rms) * PROD_W'(mdl_gain);
        prod = prod >> SHIFT_Q;
        cur = (prod > PROD_W'(16'hFFFF)) ? '1 : prod[CUR_W-1:0];
        if (cur < mdl_gate)
            cur = '0;
        r.cur = cur;
        r.pwr = PWR_W'(cur) * PWR_W'(mdl_volt);
        pending_readings.push_back(r);
        readings_expected++;
        mdl_sum = '0;
        mdl_count = '0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_reading();
        reading_t want;
        logic [RMS_W-1:0] got_rms;
        logic [CUR_W-1:0] got_cur;
        logic [PWR_W-1:0] got_pwr;
        got_rms = m_tdata[RMS_W-1:0];
        got_cur = m_tdata[RMS_W +: CUR_W];
        got_pwr = m_tdata[RMS_W + CUR_W +: PWR_W];
        if (pending_readings.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word rms_q4=%0d current_ma=%0d power_mw=%0d",
                got_rms, got_cur, got_pwr));
            return;
        end
        want = pending_readings.pop_front();
        readings_checked++;
        if (got_rms !== want.rms)
            report_mismatch($sformatf("rms_q4 got %0d want %0d", got_rms, want.rms));
        if (got_cur !== want.cur)
            report_mismatch($sformatf("current_ma got %0d want %0d", got_cur, want.cur));
        if (got_pwr !== want.pwr)
            report_mismatch($sformatf("power_mw got %0d want %0d", got_pwr, want.pwr));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_reading();
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 13);
        end
    end

    task automatic send_sample(input logic [ADC_BITS-1:0] s);
        while (!steady && $urandom_range(99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_TDATA_W'(s);
        do
            @(posedge clk);
        while (!s_tready);
        account_sample(s);
        samples_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (BACK_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ADC_MIDPOINT: mdl_mid = value[ADC_BITS-1:0];
            REG_WINDOW_LEN:   mdl_window = value[WINDOW_BITS-1:0];
            REG_GAIN:         mdl_gain = value[GAIN_W-1:0];
            REG_GATE:         mdl_gate = value[GATE_W-1:0];
            REG_VOLTAGE:      mdl_volt = value[VOLT_W-1:0];
            default:          ;
        endcase
        reg_writes++;
    endtask

    task automatic write_all(input logic [CFG_W-1:0] mid, input logic [CFG_W-1:0] win,
                             input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] gate,
                             input logic [CFG_W-1:0] volt);
        write_reg(REG_ADC_MIDPOINT, mid);
        write_reg(REG_WINDOW_LEN, win);
        write_reg(REG_GAIN, gain);
        write_reg(REG_GATE, gate);
        write_reg(REG_VOLTAGE, volt);
    endtask

    // No word may leave before the reset window is reached; the window then closes exactly
    // at its new length with the reset scaling.
    task automatic test_default_window();
        for (int i = 0; i < 100; i++)
            send_sample($urandom_range(0, 4095));
        wait_idle();
        write_reg(REG_WINDOW_LEN, 24'd101);
        send_sample($urandom_range(0, 4095));
        wait_idle();
        write_reg(REG_WINDOW_LEN, 24'd2000);
    endtask

    // The count passes the new, shorter length, so the next word closes the window.
    task automatic test_window_shrink();
        for (int i = 0; i < 40; i++)
            send_sample(12'd4095);
        wait_idle();
        write_reg(REG_WINDOW_LEN, 24'd1);
        send_sample(12'd4095);
        wait_idle();
        write_reg(REG_WINDOW_LEN, 24'd2000);
        for (int i = 0; i < 10; i++)
            send_sample($urandom_range(0, 4095));
        wait_idle();
        write_reg(REG_WINDOW_LEN, 24'd5);
        send_sample(12'd0);
        wait_idle();
    endtask

    task automatic test_field_extremes();
        write_all(24'd0, 24'd0, 24'hFFFFFF, 24'd0, 24'd500);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd1);
        send_sample(12'd2048);
        send_sample(12'd2);
        send_sample(12'd4094);
        send_sample(12'd1365);
        send_sample(12'd2730);
        wait_idle();
        write_reg(REG_ADC_MIDPOINT, 24'd4095);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd4094);
        wait_idle();
    endtask

    task automatic test_gain_and_gate();
        write_all(24'd2048, 24'd0, 24'd0, 24'd0, 24'd500);
        send_sample(12'd0);
        send_sample(12'd4095);
        wait_idle();
        write_reg(REG_GAIN, 24'hFFFFFF);
        write_reg(REG_GATE, 24'd65535);
        send_sample(12'd4095);
        send_sample(12'd2049);
        wait_idle();
        write_reg(REG_GATE, 24'd300);
        write_reg(REG_VOLTAGE, 24'd0);
        send_sample(12'd2049);
        send_sample(12'd2070);
        wait_idle();
        write_reg(REG_GATE, 24'd0);
        write_reg(REG_VOLTAGE, 24'd1);
        send_sample(12'd2049);
        wait_idle();
    endtask

    task automatic test_short_windows();
        int lengths[5] = '{1, 2, 3, 63, 64};
        write_all(24'd1951, 24'd1, 24'd320080, 24'd80, 24'd127);
        foreach (lengths[k])
        begin
            write_reg(REG_WINDOW_LEN, CFG_W'(lengths[k]));
            for (int i = 0; i < lengths[k]; i++)
                send_sample($urandom_range(0, 4095));
            wait_idle();
        end
    endtask

    task automatic test_long_window();
        write_all(24'd0, 24'd130, 24'hFFFFFF, 24'd0, 24'd500);
        steady = 1'b1;
        for (int i = 0; i < 130; i++)
            send_sample(($urandom_range(99) < 95) ? 12'd4095 : 12'($urandom_range(0, 4095)));
        wait_idle();
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        write_all(CFG_W'($urandom_range(0, 4095)), 24'd2, 24'd320080, 24'd80, 24'd230);
        hold_left = 600;
        for (int i = 0; i < 80; i++)
            send_sample($urandom_range(0, 4095));
        wait_idle();
        write_reg(REG_WINDOW_LEN, 24'd3);
        for (int i = 0; i < 30; i++)
            send_sample($urandom_range(0, 4095));
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 30; i++)
            send_sample($urandom_range(0, 4095));
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int items;
        int n;
        int style;
        int amp;
        int v;
        int pick;
        logic [CFG_W-1:0] value;
        items = 0;
        while (items < 320)
        begin
            wait_idle();
            if ($urandom_range(9) < 7)
            begin
                pick = $urandom_range(3);
                value = (pick == 0) ? CFG_W'(0) : (pick == 1) ? CFG_W'(4095)
                        : CFG_W'($urandom_range(0, 4095));
                write_reg(REG_ADC_MIDPOINT, value);
            end
            if ($urandom_range(9) < 7)
            begin
                pick = $urandom_range(99);
                value = (pick < 45) ? CFG_W'($urandom_range(0, 8))
                        : (pick < 80) ? CFG_W'($urandom_range(9, 40))
                        : CFG_W'($urandom_range(41, 160));
                write_reg(REG_WINDOW_LEN, value);
            end
            if ($urandom_range(9) < 7)
            begin
                pick = $urandom_range(7);
                value = (pick == 0) ? CFG_W'(0) : (pick == 1) ? CFG_W'(24'hFFFFFF)
                        : CFG_W'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 10));
                write_reg(REG_GAIN, value);
            end
            if ($urandom_range(9) < 7)
            begin
                pick = $urandom_range(7);
                value = (pick == 0) ? CFG_W'($urandom_range(0, 65535))
                        : CFG_W'($urandom_range(0, 200));
                write_reg(REG_GATE, value);
            end
            if ($urandom_range(9) < 7)
                write_reg(REG_VOLTAGE, CFG_W'($urandom_range(0, 500)));
            n = $urandom_range(20, 90);
            style = $urandom_range(3);
            amp = $urandom_range(1, 2047);
            for (int i = 0; i < n; i++)
            begin
                if (style == 0)
                    v = $urandom_range(0, 4095);
                else if (style == 1)
                    v = $urandom_range(1) ? 4095 : 0;
                else
                begin
                    v = int'(mdl_mid) + $urandom_range(0, 2 * amp) - amp;
                    v = (v < 0) ? 0 : (v > 4095) ? 4095 : v;
                end
                send_sample(12'(v));
                items++;
            end
        end
    endtask

    initial
    begin
        model_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_window();
        test_window_shrink();
        test_field_extremes();
        test_gain_and_gate();
        test_short_windows();
        test_long_window();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        $display("Sent %0d samples, checked %0d window readings, made %0d register writes.",
            samples_sent, readings_checked, reg_writes);
        $display("Covered zero, short, shrunk and full-scale windows, gating and saturation.");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/rcm_pkg.sv
rtl/core/rcm_front.sv
rtl/core/rcm_queue.sv
rtl/core/rcm_back.sv
rtl/core/rms_current_meter_top.sv
test/tb_rms_current_meter_top.sv
